@@ rtl/srdc_pkg.sv @@
// ----------------------------------------------------------------------------
// srdc_pkg
// shared types, constants and sha-256 helper functions for the row digest chain
// ----------------------------------------------------------------------------
package srdc_pkg;

    localparam int MAX_ROW_WORDS = 65536;
    localparam int CNT_W         = 17;
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_ROW_WORDS + 1);
    localparam logic [16:0] ROW_WORDS_RST = 17'd4096;
    localparam logic [31:0] UPTO_RST      = 32'hFFFF_FFFF;
    localparam logic [31:0] PAD_WORD      = 32'h8000_0000;
    localparam logic [31:0] FOLD_BITS     = 32'd544;

    localparam logic [0:0] REG_ROW_WORDS = 1'b0;
    localparam logic [0:0] REG_UPTO      = 1'b1;

    typedef struct packed {
        logic [31:0] row_word;
        logic [31:0] position;
        logic        start_sequence;
        logic        row_end;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_part;
        logic [1:0]  part_index;
        logic        last_part;
        logic        row_folded;
        logic        shape_error;
    } t_out_item;

    typedef logic [7:0][31:0] t_hash;

    // control from sequencer to compression core
    typedef struct packed {
        logic  start;
        t_hash h_in;
    } t_core_cmd;

    typedef struct packed {
        logic  done;
        t_hash h_out;
    } t_core_rsp;

    localparam t_hash KINIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

    function automatic logic [31:0] kround(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bswap(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

@@ rtl/srdc_core.sv @@
// ----------------------------------------------------------------------------
// srdc_core
// sha-256 compression, one round per cycle over a 16-word sliding schedule
// ----------------------------------------------------------------------------
module srdc_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  srdc_pkg::t_core_cmd     i_cmd,
    input  logic [15:0][31:0]       i_blk,
    output srdc_pkg::t_core_rsp     o_rsp
);

    logic              r_busy;
    logic [5:0]        r_rnd;
    logic [15:0][31:0] r_w;
    srdc_pkg::t_hash   r_v;
    srdc_pkg::t_hash   r_h;
    logic              r_done;

    logic [31:0] w_s0, w_s1, w_new, w_t1, w_t2, w_e, w_a;

    always_comb begin
        w_s0  = srdc_pkg::rotr(r_w[1], 7) ^ srdc_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_s1  = srdc_pkg::rotr(r_w[14], 17) ^ srdc_pkg::rotr(r_w[14], 19)
              ^ (r_w[14] >> 10);
        w_new = r_w[0] + w_s0 + r_w[9] + w_s1;
        w_e   = r_v[4];
        w_a   = r_v[0];
        w_t1  = r_v[7] + (srdc_pkg::rotr(w_e, 6) ^ srdc_pkg::rotr(w_e, 11)
              ^ srdc_pkg::rotr(w_e, 25)) + ((w_e & r_v[5]) ^ (~w_e & r_v[6]))
              + srdc_pkg::kround(r_rnd) + r_w[0];
        w_t2  = (srdc_pkg::rotr(w_a, 2) ^ srdc_pkg::rotr(w_a, 13)
              ^ srdc_pkg::rotr(w_a, 22)) + ((w_a & r_v[1]) ^ (w_a & r_v[2])
              ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start && !r_busy) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
                r_w    <= i_blk;
                r_v    <= i_cmd.h_in;
                r_h    <= i_cmd.h_in;
            end else if (r_busy) begin
                r_w <= {w_new, r_w[15:1]};
                r_v <= {r_v[6:4], r_v[3] + w_t1, r_v[2:0], w_t1 + w_t2};
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            if (r_done) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    // the registered feed-forward add lands in the cycle after done; expose the sum directly
    always_comb begin
        o_rsp.done = r_done;
        for (int i = 0; i < 8; i++) o_rsp.h_out[i] = r_h[i] + r_v[i];
    end

endmodule

@@ rtl/sha256_row_digest_chain.sv @@
// ----------------------------------------------------------------------------
// sha256_row_digest_chain
// per-row sha-256 folded into a running 256-bit chain digest
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// in       in   i_valid / o_ready  t_in_item  (one row word)
// out      out  o_valid / i_ready  t_out_item (four parts after each row end)
// cfg      in   i_cfg_valid/o_cfg_ready  index, 32-bit data
//
// every compression holds the shared round unit: launch, 64 rounds, done; a word
// that fills a 16-word block adds one compression, other words add none; a row
// end adds 1 or 2 padding compressions, a decision state, plus 2 compressions
// for the fold when it folds, then four output items
// the single compression core runs one round per cycle
// reset is synchronous: registers restored, chain cleared; block buffer not reset
// output stalls hold the sequencer in its emit state, no item lost
// ----------------------------------------------------------------------------
module sha256_row_digest_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  srdc_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output srdc_pkg::t_out_item o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [0:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_BLK  = 8'b0000_0010,  // full data block in the core
        ST_PAD1 = 8'b0000_0100,  // extra padding block when length slot is used
        ST_PAD2 = 8'b0000_1000,  // final padding block with bit length
        ST_DEC  = 8'b0001_0000,  // error, stop and fold decision
        ST_FLD1 = 8'b0010_0000,
        ST_FLD2 = 8'b0100_0000,
        ST_EMIT = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic   r_wait;                // core launched, waiting for done

    logic [16:0] r_row_words;
    logic [31:0] r_upto;
    logic [3:0][63:0] r_acc;
    srdc_pkg::t_hash  r_rh;        // running row hash
    logic [31:0] r_rh_w7;          // last row hash word, needed by the second fold block
    logic [15:0][31:0] r_buf;      // block buffer
    logic [16:0] r_cnt;
    logic [61:0] r_nwords;         // byte length / 4
    logic        r_stop, r_err, r_folded;
    logic [31:0] r_pos;
    logic [1:0]  r_part;
    logic        r_twopad;

    srdc_pkg::t_core_cmd w_cmd;
    srdc_pkg::t_core_rsp w_rsp;
    logic [15:0][31:0]   w_blk;
    logic [3:0]          w_slot;

    srdc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_blk   (w_blk),
        .o_rsp   (w_rsp)
    );

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_slot      = r_nwords[3:0];

    // padding of the row tail: 0x80 word at the slot, zeros after, length last
    logic [15:0][31:0] w_pad;
    logic [63:0]       w_bits;
    always_comb begin
        w_bits = {r_nwords, 2'b00} << 3;
        for (int i = 0; i < 16; i++) begin
            if (4'(i) < w_slot)       w_pad[i] = r_buf[i];
            else if (4'(i) == w_slot) w_pad[i] = srdc_pkg::PAD_WORD;
            else                      w_pad[i] = '0;
        end
    end

    // fold message: acc, position, row hash, pad, length 544 bits
    logic [31:0][31:0] w_msg;
    always_comb begin
        w_msg = '0;
        for (int i = 0; i < 4; i++) begin
            w_msg[2*i]   = r_acc[i][63:32];
            w_msg[2*i+1] = r_acc[i][31:0];
        end
        w_msg[8] = srdc_pkg::bswap(r_pos);
        for (int i = 0; i < 7; i++) w_msg[9+i] = r_rh[i];
        w_msg[16] = r_rh_w7;
        w_msg[17] = srdc_pkg::PAD_WORD;
        w_msg[31] = srdc_pkg::FOLD_BITS;
    end

    always_comb begin
        w_cmd.start = 1'b0;
        w_cmd.h_in  = r_rh;
        w_blk       = r_buf;
        unique case (r_state)
            ST_BLK: begin
                w_cmd.start = !r_wait;
            end
            ST_PAD1: begin
                // only a tail at slot 14 or 15 needs this block
                w_cmd.start = !r_wait && (w_slot >= 4'd14);
                w_blk       = w_pad;
            end
            ST_PAD2: begin
                w_cmd.start = !r_wait;
                if (r_twopad) w_blk = '0;
                else          w_blk = w_pad;
                w_blk[14] = w_bits[63:32];
                w_blk[15] = w_bits[31:0];
            end
            ST_FLD1: begin
                w_cmd.start = !r_wait;
                w_cmd.h_in  = srdc_pkg::KINIT;
                w_blk       = w_msg[15:0];
            end
            ST_FLD2: begin
                w_cmd.start = !r_wait;
                w_blk       = w_msg[31:16];
            end
            default: ;
        endcase
    end

    logic w_zero;
    assign w_zero = r_err || (r_row_words == '0);

    always_comb begin
        o_valid            = (r_state == ST_EMIT);
        o_item.digest_part = w_zero ? 64'd0 : r_acc[r_part];
        o_item.part_index  = r_part;
        o_item.last_part   = (r_part == 2'd3);
        o_item.row_folded  = r_folded;
        o_item.shape_error = r_err;
    end

    // running hash register carries the fold chaining value between the fold blocks
    logic [3:0][63:0] w_acc_new;
    always_comb begin
        for (int i = 0; i < 4; i++) w_acc_new[i] = {w_rsp.h_out[2*i], w_rsp.h_out[2*i+1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= 1'b0;
            r_row_words <= srdc_pkg::ROW_WORDS_RST;
            r_upto      <= srdc_pkg::UPTO_RST;
            r_acc       <= '0;
            r_rh        <= srdc_pkg::KINIT;
            r_cnt       <= '0;
            r_nwords    <= '0;
            r_stop      <= 1'b0;
            r_err       <= 1'b0;
            r_folded    <= 1'b0;
            r_part      <= '0;
            r_twopad    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    srdc_pkg::REG_ROW_WORDS: r_row_words <= i_cfg_data[16:0];
                    srdc_pkg::REG_UPTO:      r_upto      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_cmd.start) r_wait <= 1'b1;
            if (w_rsp.done)  r_wait <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin : accept
                        logic [3:0]  v_slot;
                        logic [16:0] v_cnt;
                        v_slot = i_item.start_sequence ? 4'd0 : w_slot;
                        v_cnt  = i_item.start_sequence ? 17'd0 : r_cnt;
                        if (i_item.start_sequence) begin
                            r_acc  <= '0;
                            r_stop <= 1'b0;
                            r_err  <= 1'b0;
                            r_rh   <= srdc_pkg::KINIT;
                            r_nwords <= 62'd1;
                        end else begin
                            r_nwords <= r_nwords + 62'd1;
                        end
                        r_buf[v_slot] <= srdc_pkg::bswap(i_item.row_word);
                        if (v_cnt != srdc_pkg::CNT_SAT) r_cnt <= v_cnt + 17'd1;
                        else                            r_cnt <= v_cnt;
                        r_pos    <= i_item.position;
                        r_twopad <= 1'b0;
                        if (v_slot == 4'd15)   r_state <= ST_BLK;
                        else if (i_item.row_end) r_state <= ST_PAD1;
                        if (v_slot == 4'd15 && i_item.row_end) r_twopad <= 1'b1;
                    end
                end
                ST_BLK: begin
                    if (w_rsp.done) begin
                        r_rh <= w_rsp.h_out;
                        // r_twopad here marks a pending row end
                        r_state  <= r_twopad ? ST_PAD1 : ST_IDLE;
                        r_twopad <= 1'b0;
                    end
                end
                ST_PAD1: begin
                    // slot 14 or 15 needs its own padding block first
                    if (w_slot < 4'd14 && !r_wait) begin
                        r_state <= ST_PAD2;
                    end else if (w_rsp.done) begin
                        r_rh     <= w_rsp.h_out;
                        r_twopad <= 1'b1;
                        r_state  <= ST_PAD2;
                    end
                end
                ST_PAD2: begin
                    if (w_rsp.done) begin
                        r_rh    <= w_rsp.h_out;
                        r_state <= ST_DEC;
                    end
                end
                ST_DEC: begin : decide
                    logic v_err, v_stop;
                    v_err  = r_err || (r_row_words > 17'(srdc_pkg::MAX_ROW_WORDS))
                           || (r_cnt != r_row_words);
                    v_stop = r_stop || (r_pos >= r_upto);
                    r_err    <= v_err;
                    r_stop   <= v_stop;
                    r_folded <= 1'b0;
                    r_part   <= '0;
                    r_rh_w7  <= r_rh[7];
                    if (!v_stop && !v_err && r_row_words != '0) begin
                        r_folded <= 1'b1;
                        r_state  <= ST_FLD1;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_FLD1: begin
                    if (w_rsp.done) begin
                        r_rh    <= w_rsp.h_out;
                        r_state <= ST_FLD2;
                    end
                end
                ST_FLD2: begin
                    if (w_rsp.done) begin
                        r_acc   <= w_acc_new;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (i_ready) begin
                        r_part <= r_part + 2'd1;
                        if (r_part == 2'd3) begin
                            r_state  <= ST_IDLE;
                            r_rh     <= srdc_pkg::KINIT;
                            r_cnt    <= '0;
                            r_nwords <= '0;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/srdc_checker.sv @@
// ----------------------------------------------------------------------------
// srdc_checker
// port-level checks on the row digest chain
// ----------------------------------------------------------------------------
module srdc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input srdc_pkg::t_out_item o_item
);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("input taken while emitting");

    a_part_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_item.last_part |=> o_valid
        && o_item.part_index == $past(o_item.part_index) + 2'd1)
        else $error("parts out of order");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.last_part == (o_item.part_index == 2'd3)))
        else $error("last part flag wrong");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.shape_error |-> o_item.digest_part == 64'd0)
        else $error("digest not zero on error");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("output item changed under stall");

endmodule

bind sha256_row_digest_chain srdc_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);

@@ test/tb_sha256_row_digest_chain.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha256_row_digest_chain
// drives rows of words through the digest chain and checks every digest part
// against a sha-256 chain predictor kept in the testbench; a short directed
// table first, then three random phases with different idling on both sides
// ----------------------------------------------------------------------------
module tb_sha256_row_digest_chain;

    typedef logic [15:0][31:0] t_block;

    // kinds of table rows
    typedef enum logic [0:0] {
        ST_ITEM = 1'b0,
        ST_CFG  = 1'b1
    } t_step_kind;

    typedef struct {
        t_step_kind          kind;
        logic [0:0]          cfg_index;
        logic [31:0]         cfg_data;
        srdc_pkg::t_in_item  item;
        bit                  typed;     // expected parts given in the table
        srdc_pkg::t_out_item typed_val; // part_index and last_part filled in per part
    } t_step;

    // sha-256 round constants
    localparam logic [0:63][31:0] RC = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam int QUIET_CYCLES = 400;  // longer than a row end's compressions

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    srdc_pkg::t_in_item  i_item;
    logic                o_valid;
    logic                i_ready;
    srdc_pkg::t_out_item o_item;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [0:0]          i_cfg_index;
    logic [31:0]         i_cfg_data;

    sha256_row_digest_chain u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [16:0]      mdl_row_words;
    logic [31:0]      mdl_upto;
    logic [3:0][63:0] mdl_acc;
    srdc_pkg::t_hash  mdl_rh_state;
    t_block           mdl_blk;
    logic [16:0]      mdl_cnt;
    logic [63:0]      mdl_bytes;
    bit               mdl_stopped;
    bit               mdl_err;

    srdc_pkg::t_out_item digest_parts_due[$];
    int        fails;
    int        send_idle_pct;
    int        recv_idle_pct;

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] swap_bytes(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // one 64-round compression; word i of the block is blk[i]
    function automatic srdc_pkg::t_hash sha_compress(input srdc_pkg::t_hash h,
                                                     input t_block blk);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = h[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RC[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
        return h;
    endfunction

    task automatic clear_row_state();
        mdl_rh_state = srdc_pkg::KINIT;
        mdl_cnt      = '0;
        mdl_bytes    = '0;
    endtask

    // advance the chain predictor by one accepted item, queue its digest parts
    task automatic predict_chain(input srdc_pkg::t_in_item it, input bit typed,
                                 input srdc_pkg::t_out_item tv);
        logic [3:0]          slot;
        srdc_pkg::t_hash     rh;
        srdc_pkg::t_hash     fh;
        logic [63:0]         bits;
        t_block              m_lo, m_hi;
        bit                  folded;
        srdc_pkg::t_out_item part;
        folded = 1'b0;
        if (it.start_sequence) begin
            mdl_acc     = '0;
            mdl_stopped = 1'b0;
            mdl_err     = 1'b0;
            clear_row_state();
        end
        slot = mdl_bytes[5:2];
        mdl_blk[slot] = swap_bytes(it.row_word);
        mdl_bytes = mdl_bytes + 64'd4;
        if (mdl_cnt < srdc_pkg::CNT_SAT) mdl_cnt = mdl_cnt + 17'd1;
        if (slot == 4'd15) mdl_rh_state = sha_compress(mdl_rh_state, mdl_blk);
        if (!it.row_end) return;

        // padding: marker word, zeros, bit length in the last two words
        slot = mdl_bytes[5:2];
        bits = mdl_bytes << 3;
        rh = mdl_rh_state;
        mdl_blk[slot] = srdc_pkg::PAD_WORD;
        for (int i = 0; i < 16; i++) if (i > slot) mdl_blk[i] = '0;
        if (slot >= 4'd14) begin
            rh = sha_compress(rh, mdl_blk);
            mdl_blk = '0;
        end
        mdl_blk[14] = bits[63:32];
        mdl_blk[15] = bits[31:0];
        rh = sha_compress(rh, mdl_blk);

        if (mdl_row_words > 17'(srdc_pkg::MAX_ROW_WORDS) || mdl_cnt != mdl_row_words)
            mdl_err = 1'b1;
        if (!mdl_stopped && it.position >= mdl_upto) mdl_stopped = 1'b1;
        if (!mdl_stopped && !mdl_err && mdl_row_words != 0) begin
            // fold message: acc, position le, row hash, pad, 544-bit length
            m_lo = '0;
            m_hi = '0;
            for (int i = 0; i < 4; i++) begin
                m_lo[2*i]   = mdl_acc[i][63:32];
                m_lo[2*i+1] = mdl_acc[i][31:0];
            end
            m_lo[8] = swap_bytes(it.position);
            for (int i = 0; i < 7; i++) m_lo[9+i] = rh[i];
            m_hi[0]  = rh[7];
            m_hi[1]  = srdc_pkg::PAD_WORD;
            m_hi[15] = srdc_pkg::FOLD_BITS;
            fh = sha_compress(srdc_pkg::KINIT, m_lo);
            fh = sha_compress(fh, m_hi);
            for (int i = 0; i < 4; i++) mdl_acc[i] = {fh[2*i], fh[2*i+1]};
            folded = 1'b1;
        end
        clear_row_state();

        for (int k = 0; k < 4; k++) begin
            if (typed) begin
                part = tv;
            end else begin
                part.digest_part = (mdl_err || mdl_row_words == 0) ? 64'd0 : mdl_acc[k];
                part.row_folded  = folded;
                part.shape_error = mdl_err;
            end
            part.part_index = 2'(k);
            part.last_part  = (k == 3);
            digest_parts_due = {digest_parts_due, part};
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    // receiver: check each accepted part, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (digest_parts_due.size() == 0) begin
                report_mismatch("unexpected item", o_item.digest_part, 64'd0);
            end else begin
                srdc_pkg::t_out_item want;
                want = digest_parts_due.pop_front();
                if (o_item.digest_part !== want.digest_part)
                    report_mismatch("digest_part", o_item.digest_part, want.digest_part);
                if (o_item.part_index !== want.part_index)
                    report_mismatch("part_index", 64'(o_item.part_index), 64'(want.part_index));
                if (o_item.last_part !== want.last_part)
                    report_mismatch("last_part", 64'(o_item.last_part), 64'(want.last_part));
                if (o_item.row_folded !== want.row_folded)
                    report_mismatch("row_folded", 64'(o_item.row_folded), 64'(want.row_folded));
                if (o_item.shape_error !== want.shape_error)
                    report_mismatch("shape_error", 64'(o_item.shape_error),
                                    64'(want.shape_error));
            end
        end
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // send one item, with random gaps before it
    task automatic send_item(input srdc_pkg::t_in_item it, input bit typed,
                             input srdc_pkg::t_out_item tv);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        predict_chain(it, typed, tv);
    endtask

    // register write, only once every digest part is back and the core is quiet
    task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
        i_valid <= 1'b0;
        while (digest_parts_due.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == srdc_pkg::REG_ROW_WORDS) mdl_row_words = data[16:0];
        else mdl_upto = data;
    endtask

    function automatic t_step cfg_step(input logic [0:0] idx, input logic [31:0] data);
        t_step s;
        s = '{kind: ST_CFG, cfg_index: idx, cfg_data: data, item: '0, typed: 1'b0,
              typed_val: '0};
        return s;
    endfunction

    function automatic t_step item_step(input logic [31:0] w, input logic [31:0] pos,
                                        input bit st, input bit en, input bit bad_shape);
        t_step s;
        s = '{kind: ST_ITEM, cfg_index: srdc_pkg::REG_ROW_WORDS, cfg_data: '0,
              item: '{row_word: w, position: pos, start_sequence: st, row_end: en},
              typed: bad_shape, typed_val: '0};
        // a shape error always reads as a zero digest, not folded
        s.typed_val.shape_error = 1'b1;
        return s;
    endfunction

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_step               dir_tab[$];
        srdc_pkg::t_in_item  it;
        srdc_pkg::t_out_item no_typed;
        int                  len, want_len;
        logic [31:0]         pos, rw;

        no_typed = '0;
        fails = 0;
        send_idle_pct = 36;
        recv_idle_pct = 82;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= srdc_pkg::REG_ROW_WORDS;
        i_cfg_data  <= '0;
        mdl_row_words = srdc_pkg::ROW_WORDS_RST;
        mdl_upto      = srdc_pkg::UPTO_RST;
        mdl_acc       = '0;
        mdl_blk       = '0;
        mdl_stopped   = 1'b0;
        mdl_err       = 1'b0;
        clear_row_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        dir_tab = {dir_tab, item_step(32'h0, 32'h0, 1, 1, 1)};  // reset row_words, 1 word
        dir_tab = {dir_tab, cfg_step(srdc_pkg::REG_ROW_WORDS, 32'd2)};
        dir_tab = {dir_tab, item_step(32'h0000_0000, 32'h0, 1, 0, 0)};
        dir_tab = {dir_tab, item_step(32'hFFFF_FFFF, 32'h0, 0, 1, 0)};
        dir_tab = {dir_tab, item_step(32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0)};
        dir_tab = {dir_tab, item_step(32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1, 0)}; // stop at top
        dir_tab = {dir_tab, item_step(32'h0000_0001, 32'h2, 0, 1, 1)};  // short row
        dir_tab = {dir_tab, cfg_step(srdc_pkg::REG_UPTO, 32'd3)};
        dir_tab = {dir_tab, item_step(32'hDEAD_BEEF, 32'h1, 1, 0, 0)};
        dir_tab = {dir_tab, item_step(32'h0000_0000, 32'h1, 0, 1, 0)};
        dir_tab = {dir_tab, item_step(32'h0000_0001, 32'h3, 0, 0, 0)};
        dir_tab = {dir_tab, item_step(32'h5555_AAAA, 32'h3, 0, 1, 0)};  // reaches upto
        dir_tab = {dir_tab, item_step(32'h1234_5678, 32'h1, 0, 0, 0)};
        dir_tab = {dir_tab, item_step(32'h9ABC_DEF0, 32'h1, 0, 1, 0)};  // still stopped
        dir_tab = {dir_tab, item_step(32'hCAFE_F00D, 32'h0, 0, 0, 0)};
        dir_tab = {dir_tab, item_step(32'hA5A5_A5A5, 32'h0, 1, 0, 0)};  // start mid row
        dir_tab = {dir_tab, item_step(32'h5A5A_5A5A, 32'h0, 0, 1, 0)};
        dir_tab = {dir_tab, cfg_step(srdc_pkg::REG_UPTO, 32'd0)};
        dir_tab = {dir_tab, item_step(32'h0F0F_0F0F, 32'h0, 1, 0, 0)};
        dir_tab = {dir_tab, item_step(32'hF0F0_F0F0, 32'h0, 0, 1, 0)};  // upto zero
        dir_tab = {dir_tab, cfg_step(srdc_pkg::REG_ROW_WORDS, 32'd0)};
        dir_tab = {dir_tab, item_step(32'h1111_1111, 32'h0, 1, 1, 0)};  // zero row_words
        dir_tab = {dir_tab, cfg_step(srdc_pkg::REG_ROW_WORDS, 32'h0001_FFFF)}; // over max
        dir_tab = {dir_tab, item_step(32'h2222_2222, 32'h7, 1, 1, 1)};
        dir_tab = {dir_tab, cfg_step(srdc_pkg::REG_ROW_WORDS, 32'(srdc_pkg::MAX_ROW_WORDS))};
        dir_tab = {dir_tab, item_step(32'h3333_3333, 32'h8, 1, 1, 1)};
        dir_tab = {dir_tab, item_step(32'h4444_4444, 32'h9, 0, 1, 1)};  // error holds

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ST_CFG)
                write_reg(dir_tab[i].cfg_index, dir_tab[i].cfg_data);
            else
                send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].typed_val);
        end

        // random phases: receiver idles most, then sender idles most, then neither
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 82 : 0;
            recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 36 : 0;
            for (int sub = 0; sub < 3; sub++) begin
                int pick;
                int items;
                pick = $urandom_range(19);
                if (pick == 0) rw = 32'd0;
                else if (pick == 1) rw = 32'd131071;
                else if (pick == 2) rw = 32'(srdc_pkg::MAX_ROW_WORDS);
                else if (pick < 6) rw = $urandom_range(14, 17);
                else rw = $urandom_range(1, 20);
                write_reg(srdc_pkg::REG_ROW_WORDS,
                          {15'($urandom_range(32767, 0)), 17'b0} | rw);
                pick = $urandom_range(3);
                write_reg(srdc_pkg::REG_UPTO, (pick == 0) ? $urandom() :
                                    (pick == 1) ? 32'hFFFF_FFFF : $urandom_range(2, 12));
                items = 0;
                pos = 0;
                while (items < 56) begin
                    // mostly well-formed rows, some short or long ones
                    want_len = (rw == 0 || rw > 64) ? $urandom_range(1, 6) : int'(rw);
                    if ($urandom_range(9) < 2)
                        len = want_len + $urandom_range(3) - 2;
                    else
                        len = want_len;
                    if (len < 1) len = 1;
                    if ($urandom_range(7) == 0) pos = $urandom();
                    for (int w = 0; w < len; w++) begin
                        it.row_word       = $urandom();
                        it.position       = ($urandom_range(9) == 0) ? $urandom() : pos;
                        it.start_sequence = (items == 0 && w == 0) ||
                                            ($urandom_range(15) == 0 && w == 0) ||
                                            ($urandom_range(99) == 0);
                        it.row_end        = (w == len - 1);
                        if (it.row_end) it.position = pos;
                        send_item(it, 1'b0, no_typed);
                        items++;
                    end
                    pos = pos + 1;
                end
            end
        end

        i_valid <= 1'b0;
        while (digest_parts_due.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
